>>> rtl/piaw_pkg.sv
package piaw_pkg;

    localparam int DEF_DATA_WIDTH = 32;
    localparam int DEF_FRAC_BITS  = 16;

    localparam int KP_W       = 31;
    localparam int TS_W       = 17;
    localparam int CFG_ADDR_W = 2;
    localparam int TUSER_W    = 2;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_KP        = 2'd0,
        REG_TS_PER_T1 = 2'd1,
        REG_OUT_MAX   = 2'd2,
        REG_OUT_MIN   = 2'd3
    } reg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL1_LO,
        ST_MUL1_HI,
        ST_PROP,
        ST_MUL2_LO,
        ST_MUL2_HI,
        ST_INTEG,
        ST_SUM,
        ST_LIMIT
    } state_t;

    typedef struct packed {
        logic load;
        logic mul_lo;
        logic mul_hi;
        logic mul_sel_p;
        logic prop;
        logic integ;
        logic sum;
        logic limit;
    } cmd_t;

    typedef struct packed {
        logic out_free;
        logic skip_mul2;
    } sts_t;

endpackage

>>> rtl/piaw_mul.sv
module piaw_mul
    import piaw_pkg::*;
#(
    parameter int A_W = DEF_DATA_WIDTH + 1,
    parameter int F_W = KP_W
) (
    input  logic               aclk,
    input  logic               lo_en,
    input  logic               hi_en,
    input  logic [A_W-1:0]     a,
    input  logic [F_W-1:0]     f,
    output logic [A_W+F_W-1:0] prod
);

    localparam int LO_W = (A_W + 1) / 2;
    localparam int HI_W = A_W - LO_W;
    localparam int P_W  = A_W + F_W;

    logic [P_W-1:0]       acc_reg, acc_next;
    logic [LO_W+F_W-1:0]  pp_lo;
    logic [HI_W+F_W-1:0]  pp_hi;

    // two partial products, low half first
    assign pp_lo = a[LO_W-1:0] * f;
    assign pp_hi = a[A_W-1:LO_W] * f;

    always_comb begin
        acc_next = acc_reg;
        if (lo_en) begin
            acc_next = P_W'(pp_lo);
        end else if (hi_en) begin
            acc_next = acc_reg + (P_W'(pp_hi) << LO_W);
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
    end

    assign prod = acc_reg;

endmodule

>>> rtl/piaw_ctrl.sv
module piaw_ctrl
    import piaw_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    output logic s_tready,
    input  sts_t sts,
    output cmd_t cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_MUL1_LO;
                end
            end
            ST_MUL1_LO: begin
                cmd.mul_lo = 1'b1;
                state_next = ST_MUL1_HI;
            end
            ST_MUL1_HI: begin
                cmd.mul_hi = 1'b1;
                state_next = ST_PROP;
            end
            ST_PROP: begin
                cmd.prop   = 1'b1;
                state_next = sts.skip_mul2 ? ST_INTEG : ST_MUL2_LO;
            end
            ST_MUL2_LO: begin
                cmd.mul_lo    = 1'b1;
                cmd.mul_sel_p = 1'b1;
                state_next    = ST_MUL2_HI;
            end
            ST_MUL2_HI: begin
                cmd.mul_hi    = 1'b1;
                cmd.mul_sel_p = 1'b1;
                state_next    = ST_INTEG;
            end
            ST_INTEG: begin
                cmd.integ     = 1'b1;
                cmd.mul_sel_p = 1'b1;
                state_next    = ST_SUM;
            end
            ST_SUM: begin
                cmd.sum    = 1'b1;
                state_next = ST_LIMIT;
            end
            ST_LIMIT: begin
                if (sts.out_free) begin
                    cmd.limit  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

`ifndef NO_ASSERTIONS
    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == ST_MUL1_LO))
        else $error("accepted word did not start the first multiply");

    a_limit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.limit |-> sts.out_free)
        else $error("result written while output register is occupied");

    a_ready_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !(cmd.mul_lo || cmd.mul_hi || cmd.prop || cmd.integ
                       || cmd.sum || cmd.limit))
        else $error("datapath busy while input is ready");

    a_limit_done: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.limit |=> s_tready)
        else $error("no return to ready after result");
`endif

endmodule

>>> rtl/piaw_dpath.sv
module piaw_dpath
    import piaw_pkg::*;
#(
    parameter int DATA_WIDTH = DEF_DATA_WIDTH,
    parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  cmd_t                  cmd,
    output sts_t                  sts,
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [(DATA_WIDTH > KP_W ? DATA_WIDTH : KP_W)-1:0] cfg_wr_data,
    input  logic [DATA_WIDTH-1:0] reference,
    input  logic [DATA_WIDTH-1:0] feedback,
    input  logic [DATA_WIDTH-1:0] preset_value,
    input  logic                  preset,
    input  logic                  clear,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [DATA_WIDTH-1:0] drive_out
);

    localparam int DW    = DATA_WIDTH;
    localparam int AW    = DW + 1;
    localparam int PW    = AW + KP_W;
    localparam int QW    = PW - FRAC_BITS;
    localparam int TSC_W = (TS_W > FRAC_BITS + 1) ? TS_W : FRAC_BITS + 1;

    localparam logic [DW-1:0]   MAG_POS = {1'b0, {(DW-1){1'b1}}};
    localparam logic [DW-1:0]   MAG_NEG = {1'b1, {(DW-1){1'b0}}};
    localparam logic [DW+1:0]   SMAX    = {3'b000, {(DW-1){1'b1}}};
    localparam logic [DW+1:0]   SMIN    = {3'b111, {(DW-1){1'b0}}};
    localparam logic [TSC_W-1:0] TS_ONE = TSC_W'(1) << FRAC_BITS;

    function automatic logic [DW+1:0] sx(input logic [DW-1:0] v);
        sx = {{2{v[DW-1]}}, v};
    endfunction

    function automatic logic [DW-1:0] sat(input logic [DW+1:0] x);
        if ($signed(x) > $signed(SMAX)) begin
            sat = MAG_POS;
        end else if ($signed(x) < $signed(SMIN)) begin
            sat = MAG_NEG;
        end else begin
            sat = x[DW-1:0];
        end
    endfunction

    // configuration
    logic [KP_W-1:0] kp_reg;
    logic [TS_W-1:0] ts_reg;
    logic [DW-1:0]   omax_reg;
    logic [DW-1:0]   omin_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kp_reg   <= KP_W'(1) << FRAC_BITS;
            ts_reg   <= '0;
            omax_reg <= MAG_POS;
            omin_reg <= MAG_NEG;
        end else if (cfg_wr_en) begin
            unique case (reg_idx_t'(cfg_addr))
                REG_KP:        kp_reg   <= cfg_wr_data[KP_W-1:0];
                REG_TS_PER_T1: ts_reg   <= cfg_wr_data[TS_W-1:0];
                REG_OUT_MAX:   omax_reg <= cfg_wr_data[DW-1:0];
                REG_OUT_MIN:   omin_reg <= cfg_wr_data[DW-1:0];
                default: ;
            endcase
        end
    end

    // sample capture
    logic [AW-1:0] err_mag_reg;
    logic          err_neg_reg;
    logic [DW-1:0] pre_reg;
    logic          preset_reg;
    logic          clear_reg;
    logic [AW-1:0] diff_a, diff_b;
    logic          err_neg;

    assign diff_a  = {reference[DW-1], reference} - {feedback[DW-1], feedback};
    assign diff_b  = {feedback[DW-1], feedback} - {reference[DW-1], reference};
    assign err_neg = $signed(reference) < $signed(feedback);

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            err_mag_reg <= err_neg ? diff_b : diff_a;
            err_neg_reg <= err_neg;
            pre_reg     <= preset_value;
            preset_reg  <= preset;
            clear_reg   <= clear;
        end
    end

    // shared multiplier
    logic [DW-1:0]   p_mag_reg, p_reg;
    logic            p_neg_reg;
    logic [TS_W-1:0] ts_eff;
    logic [AW-1:0]   mul_a;
    logic [KP_W-1:0] mul_f;
    logic [PW-1:0]   prod;
    logic [QW-1:0]   q;

    assign ts_eff = (TSC_W'(ts_reg) > TS_ONE) ? TS_W'(TS_ONE) : ts_reg;
    assign mul_a  = cmd.mul_sel_p ? AW'(p_mag_reg) : err_mag_reg;
    assign mul_f  = cmd.mul_sel_p ? KP_W'(ts_eff) : kp_reg;

    piaw_mul #(
        .A_W (AW),
        .F_W (KP_W)
    ) u_mul (
        .aclk  (aclk),
        .lo_en (cmd.mul_lo),
        .hi_en (cmd.mul_hi),
        .a     (mul_a),
        .f     (mul_f),
        .prod  (prod)
    );

    assign q = prod[PW-1:FRAC_BITS];

    // proportional term
    logic [DW-1:0] lim_mag, p_mag;
    logic          p_neg;

    always_comb begin
        lim_mag = err_neg_reg ? MAG_NEG : MAG_POS;
        p_mag   = (q > QW'(lim_mag)) ? lim_mag : q[DW-1:0];
        p_neg   = err_neg_reg;
        if (clear_reg) begin
            p_mag = '0;
            p_neg = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.prop) begin
            p_mag_reg <= p_mag;
            p_neg_reg <= p_neg;
            p_reg     <= p_neg ? (DW'(0) - p_mag) : p_mag;
        end
    end

    // integrator, sum and limits
    logic [DW-1:0] integ_reg, integ_next;
    logic [DW-1:0] y_reg;
    logic [DW-1:0] drive_reg, drive_next;
    logic          m_valid_reg, m_valid_next;
    logic [DW:0]   step;
    logic [DW+1:0] acc_sum, pre_sum, back_sum;
    logic [DW-1:0] lim_sel;
    logic          inverted, at_min, at_max;

    assign step     = p_neg_reg ? ((DW+1)'(0) - {1'b0, q[DW-1:0]}) : {1'b0, q[DW-1:0]};
    assign acc_sum  = sx(integ_reg) + {step[DW], step};
    assign pre_sum  = sx(pre_reg) - sx(p_reg);
    assign inverted = $signed(omax_reg) < $signed(omin_reg);
    assign at_min   = $signed(y_reg) <= $signed(omin_reg);
    assign at_max   = $signed(y_reg) >= $signed(omax_reg);
    assign lim_sel  = at_min ? omin_reg : omax_reg;
    assign back_sum = sx(lim_sel) - sx(p_reg);

    always_comb begin
        integ_next = integ_reg;
        drive_next = drive_reg;
        if (cmd.integ) begin
            if (clear_reg) begin
                integ_next = '0;
            end else if (preset_reg) begin
                integ_next = sat(pre_sum);
            end else begin
                integ_next = sat(acc_sum);
            end
        end
        if (cmd.limit) begin
            if (inverted) begin
                drive_next = '0;
            end else if (at_min || at_max) begin
                drive_next = lim_sel;
                integ_next = sat(back_sum);
            end else begin
                drive_next = y_reg;
            end
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.limit) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            integ_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            integ_reg   <= integ_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.sum) begin
            y_reg <= sat(sx(p_reg) + sx(integ_reg));
        end
        drive_reg <= drive_next;
    end

    assign sts.out_free  = !m_valid_reg || m_tready;
    assign sts.skip_mul2 = clear_reg || preset_reg;
    assign m_tvalid      = m_valid_reg;
    assign drive_out     = drive_reg;

endmodule

>>> rtl/pi_regulator_anti_windup_unit.sv
// pi regulator with clamping anti-windup, signed fixed point
// steps: multiply kp * error, proportional term, multiply p * ts_per_t1 (skipped with
// clear or preset), integrator, sum and limit; the shared multiplier forms each product
// as two partial products, and no new word is taken until the result is in the output register
// reset: synchronous active-low aresetn clears the integrator, the output valid and the
// sequencer, and loads kp = 1.0, ts_per_t1 = 0 and the widest output limits
module pi_regulator_anti_windup_unit
    import piaw_pkg::*;
#(
    parameter int DATA_WIDTH = DEF_DATA_WIDTH,
    parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [(DATA_WIDTH > KP_W ? DATA_WIDTH : KP_W)-1:0] cfg_wr_data,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // reference, feedback, preset_value
    input  logic [((3*DATA_WIDTH+7)/8)*8-1:0] s_tdata,
    // preset, clear
    input  logic [TUSER_W-1:0]    s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // drive_out
    output logic [((DATA_WIDTH+7)/8)*8-1:0] m_tdata
);

    localparam int DW    = DATA_WIDTH;
    localparam int OUT_W = ((DATA_WIDTH + 7) / 8) * 8;

    cmd_t          cmd;
    sts_t          sts;
    logic [DW-1:0] drive_out;

    piaw_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    piaw_dpath #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_dpath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .sts          (sts),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_addr     (cfg_addr),
        .cfg_wr_data  (cfg_wr_data),
        .reference    (s_tdata[DW-1:0]),
        .feedback     (s_tdata[2*DW-1:DW]),
        .preset_value (s_tdata[3*DW-1:2*DW]),
        .preset       (s_tuser[0]),
        .clear        (s_tuser[1]),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .drive_out    (drive_out)
    );

    assign m_tdata = OUT_W'(drive_out);

endmodule

>>> tb/pi_regulator_anti_windup_unit_test.sv
`timescale 1ns / 1ps

module pi_regulator_anti_windup_unit_test;
    import piaw_pkg::*;

    localparam int DW    = DEF_DATA_WIDTH;
    localparam int FB    = DEF_FRAC_BITS;
    localparam int CW    = (DW > KP_W) ? DW : KP_W;
    localparam int SDW   = ((3 * DW + 7) / 8) * 8;
    localparam int MDW   = ((DW + 7) / 8) * 8;
    localparam int LIMIT = 400000;

    localparam longint          DMAX  = 64'sd2147483647;
    localparam longint          DMIN  = -DMAX - 1;
    localparam longint unsigned ONE_Q = 64'd1 << FB;

    localparam logic [DW-1:0] QMAX = 32'h7FFF_FFFF;
    localparam logic [DW-1:0] QMIN = 32'h8000_0000;

    class pi_drive_board;
        longint unsigned kp_gain;
        longint unsigned ts_ratio;
        longint          lim_hi;
        longint          lim_lo;
        longint          integ;
        logic [DW-1:0]   drive_due[$];
        int              faults;

        function new();
            kp_gain  = 65536;
            ts_ratio = 0;
            lim_hi   = DMAX;
            lim_lo   = DMIN;
            integ    = 0;
            faults   = 0;
        endfunction

        function longint sat(longint x);
            if (x > DMAX) return DMAX;
            if (x < DMIN) return DMIN;
            return x;
        endfunction

        // signed value times unsigned fraction, truncated toward zero
        function longint frac_mul(longint a, longint unsigned g);
            longint unsigned mag;
            longint unsigned pr;
            mag = (a < 0) ? -a : a;
            pr  = (mag * g) >> FB;
            return (a < 0) ? -longint'(pr) : longint'(pr);
        endfunction

        function void set_reg(reg_idx_t idx, logic [CW-1:0] v);
            case (idx)
                REG_KP:        kp_gain  = v[KP_W-1:0];
                REG_TS_PER_T1: ts_ratio = v[TS_W-1:0];
                REG_OUT_MAX:   lim_hi   = longint'($signed(v[DW-1:0]));
                REG_OUT_MIN:   lim_lo   = longint'($signed(v[DW-1:0]));
                default: ;
            endcase
        endfunction

        function void take_sample(input logic [DW-1:0] r, f, pv, input logic pre, clr);
            longint          e;
            longint          p;
            longint          y;
            longint unsigned rate;
            e = longint'($signed(r)) - longint'($signed(f));
            p = sat(frac_mul(e, kp_gain));
            if (clr) begin
                p     = 0;
                integ = 0;
            end else if (pre) begin
                integ = sat(longint'($signed(pv)) - p);
            end else begin
                rate  = (ts_ratio > ONE_Q) ? ONE_Q : ts_ratio;
                integ = sat(integ + frac_mul(p, rate));
            end
            y = sat(p + integ);
            if (lim_hi < lim_lo) begin
                y = 0;
            end else if (y <= lim_lo) begin
                y     = lim_lo;
                integ = sat(y - p);
            end else if (y >= lim_hi) begin
                y     = lim_hi;
                integ = sat(y - p);
            end
            drive_due.push_back(y[DW-1:0]);
        endfunction

        function void fault(string msg);
            faults++;
            if (faults <= 10) $display("mismatch: %s", msg);
        endfunction

        function void check_drive(logic [DW-1:0] got);
            logic [DW-1:0] want;
            if (drive_due.size() == 0) begin
                fault($sformatf("unexpected drive_out %h", got));
                return;
            end
            want = drive_due.pop_front();
            if (got !== want)
                fault($sformatf("drive_out expected %h got %h", want, got));
        endfunction
    endclass

    logic            aclk;
    logic            aresetn     = 1'b0;
    logic            cfg_wr_en   = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [CW-1:0]   cfg_wr_data = '0;
    logic            s_tvalid    = 1'b0;
    logic            s_tready;
    logic [SDW-1:0]  s_tdata     = '0;
    logic [TUSER_W-1:0] s_tuser  = '0;
    logic            m_tvalid;
    logic            m_tready    = 1'b0;
    logic [MDW-1:0]  m_tdata;

    pi_drive_board   sb;
    bit              calm        = 1'b0;
    int unsigned     cycles      = 0;

    pi_regulator_anti_windup_unit u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_drive(m_tdata[DW-1:0]);
    end

    // result side stalls
    initial begin
        int stall;
        forever begin
            stall = calm ? 0 : $urandom_range(0, 8);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!(m_tvalid && m_tready));
        end
    end

    task automatic send_sample(input logic [DW-1:0] r, f, pv, input logic pre, clr);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {pv, f, r};
        s_tuser  <= {clr, pre};
        do @(posedge aclk); while (!s_tready);
        sb.take_sample(r, f, pv, pre, clr);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.drive_due.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(reg_idx_t idx, logic [CW-1:0] v);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= idx;
        cfg_wr_data <= v;
        @(posedge aclk);
        sb.set_reg(idx, v);
    endtask

    task automatic write_settings(logic [CW-1:0] kp, ts, hi, lo);
        write_reg(REG_KP, kp);
        write_reg(REG_TS_PER_T1, ts);
        write_reg(REG_OUT_MAX, hi);
        write_reg(REG_OUT_MIN, lo);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [DW-1:0] near_value(int span);
        logic [DW-1:0] v;
        v = $urandom_range(0, 2 * span) - span;
        return v;
    endfunction

    function automatic logic [DW-1:0] rand_q16();
        case ($urandom_range(0, 9))
            0:       return QMAX;
            1:       return QMIN;
            2:       return '0;
            3, 4:    return $urandom;
            default: return near_value(32'h0040_0000);
        endcase
    endfunction

    task automatic random_settings();
        logic [CW-1:0] kp;
        logic [CW-1:0] ts;
        logic [CW-1:0] hi;
        logic [CW-1:0] lo;
        int            a;
        int            b;
        case ($urandom_range(0, 5))
            0:       kp = '0;
            1:       kp = QMAX;
            2:       kp = $urandom;
            3:       kp = $urandom_range(0, 32'h0004_0000);
            default: kp = $urandom_range(32'h0000_1000, 32'h0002_0000);
        endcase
        case ($urandom_range(0, 4))
            0:       ts = '0;
            1:       ts = 32'h0001_0000;
            2:       ts = $urandom;
            default: ts = $urandom_range(1, 32'h0001_0000);
        endcase
        a = $signed(near_value(32'h0080_0000));
        b = $signed(near_value(32'h0080_0000));
        case ($urandom_range(0, 6))
            0: begin
                hi = QMAX;
                lo = QMIN;
            end
            1: begin
                hi = (a < b) ? a : b;
                lo = (a < b) ? b : a;
            end
            2: begin
                hi = a;
                lo = a;
            end
            3: begin
                hi = $urandom;
                lo = $urandom;
            end
            default: begin
                hi = (a < b) ? b : a;
                lo = (a < b) ? a : b;
            end
        endcase
        write_settings(kp, ts, hi, lo);
    endtask

    initial begin
        logic [DW-1:0] r;
        logic [DW-1:0] f;
        logic [DW-1:0] pv;
        logic          pre;
        logic          clr;

        sb = new();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // default gains and widest limits
        send_sample('0, '0, '0, 1'b0, 1'b0);
        send_sample(QMAX, QMIN, '0, 1'b0, 1'b0);
        send_sample(QMIN, QMAX, '0, 1'b0, 1'b0);
        send_sample(32'h0001_0000, '0, QMAX, 1'b1, 1'b0);
        send_sample(QMAX, '0, QMIN, 1'b1, 1'b0);
        send_sample(32'd5, 32'd3, 32'd7, 1'b0, 1'b1);
        send_sample(32'd5, 32'd3, 32'd7, 1'b1, 1'b1);
        send_sample(32'hFFFF_FFFF, '0, '0, 1'b0, 1'b0);

        // largest gain, ratio above one, narrow limits
        drain();
        write_settings(QMAX, 32'h0001_FFFF, 32'h0001_0000, 32'hFFFF_0000);
        send_sample(32'd1, '0, '0, 1'b0, 1'b0);
        send_sample('0, 32'd1, '0, 1'b0, 1'b0);
        send_sample(32'h10, '0, '0, 1'b0, 1'b0);
        send_sample('0, '0, 32'h0001_0000, 1'b1, 1'b0);
        send_sample('0, '0, 32'hFFFF_0000, 1'b1, 1'b0);
        send_sample(QMIN, QMAX, '0, 1'b0, 1'b0);
        send_sample(QMAX, QMIN, '0, 1'b0, 1'b0);

        // inverted limits, ratio exactly one
        drain();
        write_settings(32'h0000_8000, 32'h0001_0000, 32'hFFFF_FFFF, 32'h0000_0001);
        send_sample(32'h100, '0, '0, 1'b0, 1'b0);
        send_sample(32'h100, '0, '0, 1'b0, 1'b0);
        send_sample('0, 32'h0003_0000, 32'h1234_5678, 1'b1, 1'b0);
        send_sample('0, '0, '0, 1'b0, 1'b1);

        // smallest nonzero ratio
        drain();
        write_settings(32'h0000_0003, 32'd1, QMAX, QMIN);
        send_sample(QMAX, QMIN, '0, 1'b0, 1'b0);
        send_sample(32'h0000_FFFF, '0, '0, 1'b0, 1'b0);

        for (int ph = 0; ph < 9; ph++) begin
            drain();
            random_settings();
            calm = (ph % 3 == 1);
            for (int n = 0; n < 75; n++) begin
                r = rand_q16();
                if ($urandom_range(0, 9) < 6) f = r - near_value(32'h0004_0000);
                else f = rand_q16();
                pv  = ($urandom_range(0, 1) == 0) ? rand_q16() : near_value(32'h0010_0000);
                pre = ($urandom_range(0, 9) == 0);
                clr = ($urandom_range(0, 15) == 0);
                send_sample(r, f, pv, pre, clr);
                if ($urandom_range(0, 59) == 0) drain();
            end
        end
        calm = 1'b0;

        s_tvalid <= 1'b0;
        while (sb.drive_due.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (sb.faults == 0 && sb.drive_due.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
